### sv/bmmu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank map unit package
// Shared types, request and bank codes, port numbers and page helpers.
// ----------------------------------------------------------------------------
package bmmu_pkg;

    // Page split of the 64K address space
    localparam int PAGE_COUNT = 8;
    localparam int PAGE_W     = $clog2(PAGE_COUNT);

    // Address ranges for the ROM overlays
    localparam int ROM_LAST   = 32'h5FFF;
    localparam int DISK_FIRST = 32'hE000;

    // Request kinds
    localparam logic [2:0] REQ_PORT  = 3'd0;
    localparam logic [2:0] REQ_READ  = 3'd1;
    localparam logic [2:0] REQ_FETCH = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_VIDEO = 3'd4;

    // Port numbers
    localparam logic [7:0] PORT_BANK  = 8'h82;
    localparam logic [7:0] PORT_VIDEO = 8'h80;

    // Video plane codes
    localparam logic [1:0] PLANE_BLUE  = 2'd1;
    localparam logic [1:0] PLANE_GREEN = 2'd2;

    // Video bank bases
    localparam logic [15:0] BASE_BLUE      = 16'h0000;
    localparam logic [15:0] BASE_RED       = 16'h4000;
    localparam logic [15:0] BASE_GREEN     = 16'h8000;
    localparam logic [15:0] BASE_GREEN_ALT = 16'hC000;

    // Configuration register indexes
    localparam logic CFG_DISK_PRESENT = 1'b0;
    localparam logic CFG_DISK_DISABLE = 1'b1;

    typedef enum logic [1:0] {
        BANK_ROM  = 2'd0,
        BANK_USER = 2'd1,
        BANK_VID  = 2'd2,
        BANK_FOUR = 2'd3
    } t_bank;

    // One request item
    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] address;
        logic [7:0]  data;
        logic [1:0]  plane;
        logic [7:0]  plane_step;
    } t_req;

    // Update strobes decoded from an item leaving the input stage
    typedef struct packed {
        logic       bank_wr;
        logic       video_wr;
        logic [7:0] data;
    } t_port_wr;

    // First address of a page
    function automatic int page_start(input int p);
        return (p * 65536 + PAGE_COUNT - 1) / PAGE_COUNT;
    endfunction

    function automatic logic is_rom_page(input int p);
        return page_start(p) <= ROM_LAST;
    endfunction

    function automatic logic is_disk_page(input int p);
        return page_start(p) >= DISK_FIRST;
    endfunction

    // Page index of a CPU address, clamped to the last page
    function automatic logic [PAGE_W-1:0] page_of(input logic [15:0] addr);
        logic [16+PAGE_W:0] prod;
        logic [PAGE_W:0]    pg;
        prod = 17'(addr) * (PAGE_W + 17)'(PAGE_COUNT);
        pg   = prod[16+PAGE_W:16];
        if (pg >= (PAGE_W + 1)'(PAGE_COUNT)) begin
            pg = (PAGE_W + 1)'(PAGE_COUNT - 1);
        end
        return pg[PAGE_W-1:0];
    endfunction

endpackage

### sv/banked_memory_map_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banked memory map unit
// Translates CPU memory accesses and video plane reads to a bank and an
// offset, and applies bank latch and video control port writes.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; an item moves on into the
//   result register once that register is free or its result is taken, and
//   is then offered.
// Throughput: one item per cycle unless results stall; lookup and video add
//   sit between the two registers, and port writes update the maps as they
//   leave the input register, so the next item already sees them.
// Reset (synchronous, active low): empties both stages and restores the
//   power-on page maps, the video bits and the disk ROM settings.
// ----------------------------------------------------------------------------
module banked_memory_map_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // address[15:0], data[23:16], plane[25:24],
                                     // plane_step[33:26], zero fill[39:34]
    input  logic [2:0]  i_s_tuser,   // req_type[2:0]
    // Result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // bank_select[1:0], bank_offset[17:2],
                                     // force_zero[18], zero fill[23:19]
    output logic        o_m_tuser,   // access_valid
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data
);

    logic               r_in_valid;
    bmmu_pkg::t_req     r_req;
    logic               r_out_valid;
    logic               r_out_access;
    bmmu_pkg::t_bank    r_out_bank;
    logic [15:0]        r_out_offset;
    logic               r_out_zero;
    logic               r_disk_present;
    logic               r_disk_disable;

    logic               advance;
    logic               fire;
    bmmu_pkg::t_port_wr port_wr;
    bmmu_pkg::t_bank    map_bank;
    logic [15:0]        vid_offset;
    logic               vid_zero;
    logic               n_access;
    bmmu_pkg::t_bank    n_bank;
    logic [15:0]        n_offset;
    logic               n_zero;

    // Handshake: input stage moves on when the result register frees up
    assign advance     = !r_out_valid || i_m_tready;
    assign fire        = r_in_valid && advance;
    assign o_s_tready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_req.req_type   <= i_s_tuser;
            r_req.address    <= i_s_tdata[15:0];
            r_req.data       <= i_s_tdata[23:16];
            r_req.plane      <= i_s_tdata[25:24];
            r_req.plane_step <= i_s_tdata[33:26];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_present <= 1'b1;
            r_disk_disable <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bmmu_pkg::CFG_DISK_PRESENT: r_disk_present <= i_cfg_data;
                bmmu_pkg::CFG_DISK_DISABLE: r_disk_disable <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Port write decode for the item leaving the input stage
    always_comb begin
        port_wr.data     = r_req.data;
        port_wr.bank_wr  = fire && (r_req.req_type == bmmu_pkg::REQ_PORT)
                           && (r_req.address[7:0] == bmmu_pkg::PORT_BANK);
        port_wr.video_wr = fire && (r_req.req_type == bmmu_pkg::REQ_PORT)
                           && (r_req.address[7:0] == bmmu_pkg::PORT_VIDEO);
    end

    bmmu_bank_map u_bank_map (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_port         (port_wr),
        .i_disk_present (r_disk_present),
        .i_disk_disable (r_disk_disable),
        .i_req          (r_req),
        .o_bank         (map_bank)
    );

    bmmu_video u_video (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_port       (port_wr),
        .i_req        (r_req),
        .o_offset     (vid_offset),
        .o_force_zero (vid_zero)
    );

    // Result selection
    always_comb begin
        n_access = 1'b0;
        n_bank   = bmmu_pkg::BANK_ROM;
        n_offset = 16'h0000;
        n_zero   = 1'b0;
        case (r_req.req_type)
            bmmu_pkg::REQ_READ, bmmu_pkg::REQ_FETCH, bmmu_pkg::REQ_WRITE: begin
                n_access = 1'b1;
                n_bank   = map_bank;
                n_offset = r_req.address;
            end
            bmmu_pkg::REQ_VIDEO: begin
                n_access = 1'b1;
                n_bank   = bmmu_pkg::BANK_VID;
                n_offset = vid_offset;
                n_zero   = vid_zero;
            end
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_access <= n_access;
            r_out_bank   <= n_bank;
            r_out_offset <= n_offset;
            r_out_zero   <= n_zero;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_access;
    assign o_m_tdata  = {5'b00000, r_out_zero, r_out_offset, r_out_bank};

    // Non-access results carry all zero fields
    a_port_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 24'h000000))
        else $error("non-access result with nonzero fields");

    // Blanking only ever flags a video bank result
    a_zero_vid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[18]) |-> (o_m_tdata[1:0] == bmmu_pkg::BANK_VID))
        else $error("force_zero on a non-video bank");

    // An accepted item always lands in the input stage
    a_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_in_valid)
        else $error("accepted item lost at input stage");

    // A stalled result holds its fields until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

### sv/bmmu_bank_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank map registers
// Holds the read, fetch and write bank of every page, applies latch writes
// and looks up the bank for a memory access.
// ----------------------------------------------------------------------------
module bmmu_bank_map (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bmmu_pkg::t_port_wr  i_port,
    input  logic                i_disk_present,
    input  logic                i_disk_disable,
    input  bmmu_pkg::t_req      i_req,
    output bmmu_pkg::t_bank     o_bank
);

    bmmu_pkg::t_bank r_read  [bmmu_pkg::PAGE_COUNT];
    bmmu_pkg::t_bank r_fetch [bmmu_pkg::PAGE_COUNT];
    bmmu_pkg::t_bank r_write [bmmu_pkg::PAGE_COUNT];

    logic                      wr_hit;
    bmmu_pkg::t_bank           wr_bank;
    logic                      rf_hit;
    bmmu_pkg::t_bank           rd_bank;
    bmmu_pkg::t_bank           fe_bank;
    logic                      rom_on;
    logic                      disk_on;
    logic [bmmu_pkg::PAGE_W-1:0] page;

    // Whole-map values chosen by the latch byte
    always_comb begin
        wr_hit  = 1'b0;
        wr_bank = bmmu_pkg::BANK_USER;
        if (i_port.data[6]) begin
            wr_hit  = 1'b1;
            wr_bank = bmmu_pkg::BANK_VID;
        end
        if (!i_port.data[7]) begin
            wr_hit  = 1'b1;
            wr_bank = bmmu_pkg::BANK_USER;
        end
        if (i_port.data[4]) begin
            wr_hit  = 1'b1;
            wr_bank = bmmu_pkg::BANK_FOUR;
        end

        rf_hit  = 1'b1;
        rd_bank = bmmu_pkg::BANK_USER;
        fe_bank = bmmu_pkg::BANK_USER;
        case (i_port.data[2:1])
            2'b00: begin
                rd_bank = bmmu_pkg::BANK_USER;
                fe_bank = bmmu_pkg::BANK_USER;
            end
            2'b01: begin
                rd_bank = bmmu_pkg::BANK_VID;
                fe_bank = bmmu_pkg::BANK_USER;
            end
            2'b11: begin
                rd_bank = bmmu_pkg::BANK_VID;
                fe_bank = bmmu_pkg::BANK_VID;
            end
            default: begin
                rf_hit  = i_port.data[0];
                rd_bank = bmmu_pkg::BANK_FOUR;
                fe_bank = bmmu_pkg::BANK_FOUR;
            end
        endcase

        rom_on  = !i_port.data[3];
        disk_on = rom_on && i_disk_present && !i_disk_disable;
    end

    // Per-page map registers
    for (genvar p = 0; p < bmmu_pkg::PAGE_COUNT; p++) begin : g_page
        localparam logic ROM_PG  = bmmu_pkg::is_rom_page(p);
        localparam logic DISK_PG = bmmu_pkg::is_disk_page(p);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_read[p]  <= ROM_PG ? bmmu_pkg::BANK_ROM : bmmu_pkg::BANK_USER;
                r_fetch[p] <= ROM_PG ? bmmu_pkg::BANK_ROM : bmmu_pkg::BANK_USER;
                r_write[p] <= bmmu_pkg::BANK_USER;
            end else if (i_port.bank_wr) begin
                if (wr_hit) begin
                    r_write[p] <= wr_bank;
                end
                if ((rom_on && ROM_PG) || (disk_on && DISK_PG)) begin
                    r_read[p]  <= bmmu_pkg::BANK_ROM;
                    r_fetch[p] <= bmmu_pkg::BANK_ROM;
                end else if (rf_hit) begin
                    r_read[p]  <= rd_bank;
                    r_fetch[p] <= fe_bank;
                end
            end
        end
    end

    // Lookup for the item in the input stage
    assign page = bmmu_pkg::page_of(i_req.address);

    always_comb begin
        case (i_req.req_type)
            bmmu_pkg::REQ_READ:  o_bank = r_read[page];
            bmmu_pkg::REQ_FETCH: o_bank = r_fetch[page];
            bmmu_pkg::REQ_WRITE: o_bank = r_write[page];
            default:             o_bank = bmmu_pkg::BANK_VID;
        endcase
    end

endmodule

### sv/bmmu_video.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video plane translation
// Holds the alternate green and blanking bits and maps a plane read to an
// offset inside the video bank.
// ----------------------------------------------------------------------------
module bmmu_video (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bmmu_pkg::t_port_wr i_port,
    input  bmmu_pkg::t_req     i_req,
    output logic [15:0]        o_offset,
    output logic               o_force_zero
);

    logic        r_alt_green;
    logic        r_planes_shown;
    logic [15:0] base;
    logic [15:0] off;

    // Port 0x80 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt_green    <= 1'b0;
            r_planes_shown <= 1'b1;
        end else if (i_port.video_wr) begin
            r_alt_green    <= i_port.data[4];
            r_planes_shown <= !i_port.data[5];
        end
    end

    // Plane base; code 3 falls back to red
    always_comb begin
        case (i_req.plane)
            bmmu_pkg::PLANE_BLUE:  base = bmmu_pkg::BASE_BLUE;
            bmmu_pkg::PLANE_GREEN: base = r_alt_green ? bmmu_pkg::BASE_GREEN_ALT
                                                      : bmmu_pkg::BASE_GREEN;
            default:               base = bmmu_pkg::BASE_RED;
        endcase
    end

    // Offset wrapped to 16K, then stepped, then rebased (wraps at 64K)
    assign off          = {2'b00, i_req.address[13:0]} + {8'h00, i_req.plane_step};
    assign o_offset     = base + off;
    assign o_force_zero = !r_planes_shown;

endmodule

### tb/sv/bank_map_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank map checker
// Watches the request, result and configuration channels of the bank map
// unit, keeps its own copy of the page maps and video bits, predicts the
// translation of every accepted request and compares each accepted result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bank_map_checker
    import bmmu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // address[15:0], data[23:16], plane[25:24],
                                     // plane_step[33:26], zero fill[39:34]
    input  logic [2:0]  i_s_tuser,   // req_type[2:0]
    // Result channel
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // bank_select[1:0], bank_offset[17:2],
                                     // force_zero[18], zero fill[23:19]
    input  logic        i_m_tuser,   // access_valid
    // Configuration channel
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    // Status toward the top
    output int          o_pending,
    output int          o_fail_count
);

    // Bank latch bits (port 0x82)
    localparam int LB_FOUR_EN   = 0;
    localparam int LB_NO_ROM    = 3;
    localparam int LB_WR_FOUR   = 4;
    localparam int LB_WR_VID    = 6;
    localparam int LB_WR_USER_N = 7;

    // Read/fetch select, latch bits 2..1
    localparam logic [1:0] SEL_USER   = 2'b00;
    localparam logic [1:0] SEL_RD_VID = 2'b01;
    localparam logic [1:0] SEL_VID    = 2'b11;

    // Video control bits (port 0x80)
    localparam int VC_ALT_GREEN = 4;
    localparam int VC_BLANK     = 5;

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic        access_valid;
        t_bank       bank;
        logic [15:0] offset;
        logic        force_zero;
    } t_xlat;

    // Shadow state
    t_bank rd_map [PAGE_COUNT];
    t_bank fe_map [PAGE_COUNT];
    t_bank wr_map [PAGE_COUNT];
    logic  alt_green;
    logic  planes_shown;
    logic  disk_present;
    logic  disk_disable;

    t_xlat expected_xlat [$];
    int    fail_total;

    t_req  seen_req;
    t_xlat want;
    t_xlat got;

    assign o_fail_count = fail_total;

    // First CPU address of a page
    function automatic int first_addr(input int p);
        return (p * 65536 + PAGE_COUNT - 1) / PAGE_COUNT;
    endfunction

    // Port 0x82: rewrite the page maps
    function automatic void apply_bank_latch(input logic [7:0] v);
        logic  wr_hit;
        logic  rf_hit;
        t_bank wr_new;
        t_bank rd_new;
        t_bank fe_new;
        wr_hit = 1'b0;
        rf_hit = 1'b1;
        wr_new = BANK_USER;
        rd_new = BANK_USER;
        fe_new = BANK_USER;
        // last matching rule wins
        if (v[LB_WR_VID]) begin
            wr_hit = 1'b1;
            wr_new = BANK_VID;
        end
        if (!v[LB_WR_USER_N]) begin
            wr_hit = 1'b1;
            wr_new = BANK_USER;
        end
        if (v[LB_WR_FOUR]) begin
            wr_hit = 1'b1;
            wr_new = BANK_FOUR;
        end
        case (v[2:1])
            SEL_USER: begin
                rd_new = BANK_USER;
                fe_new = BANK_USER;
            end
            SEL_RD_VID: begin
                rd_new = BANK_VID;
                fe_new = BANK_USER;
            end
            SEL_VID: begin
                rd_new = BANK_VID;
                fe_new = BANK_VID;
            end
            default: begin
                // bank four only with bit 0, else maps stay
                rf_hit = v[LB_FOUR_EN];
                rd_new = BANK_FOUR;
                fe_new = BANK_FOUR;
            end
        endcase
        for (int p = 0; p < PAGE_COUNT; p++) begin
            if (wr_hit) begin
                wr_map[p] = wr_new;
            end
            if (rf_hit) begin
                rd_map[p] = rd_new;
                fe_map[p] = fe_new;
            end
            // ROM overlay, plus disk ROM at the top when fitted and enabled
            if (!v[LB_NO_ROM]) begin
                if (first_addr(p) <= ROM_LAST) begin
                    rd_map[p] = BANK_ROM;
                    fe_map[p] = BANK_ROM;
                end
                if (disk_present && !disk_disable && first_addr(p) >= DISK_FIRST) begin
                    rd_map[p] = BANK_ROM;
                    fe_map[p] = BANK_ROM;
                end
            end
        end
    endfunction

    // Predict one result and apply the side effects of a request
    function automatic t_xlat translate_req(input t_req r);
        t_xlat       x;
        int          pg;
        logic [15:0] base;
        x  = '0;
        pg = (int'(r.address) * PAGE_COUNT) >> 16;
        if (pg >= PAGE_COUNT) begin
            pg = PAGE_COUNT - 1;
        end
        case (r.req_type)
            REQ_PORT: begin
                if (r.address[7:0] == PORT_BANK) begin
                    apply_bank_latch(r.data);
                end else if (r.address[7:0] == PORT_VIDEO) begin
                    alt_green    = r.data[VC_ALT_GREEN];
                    planes_shown = !r.data[VC_BLANK];
                end
            end
            REQ_READ, REQ_FETCH, REQ_WRITE: begin
                x.access_valid = 1'b1;
                x.offset       = r.address;
                if (r.req_type == REQ_READ) begin
                    x.bank = rd_map[pg];
                end else if (r.req_type == REQ_FETCH) begin
                    x.bank = fe_map[pg];
                end else begin
                    x.bank = wr_map[pg];
                end
            end
            REQ_VIDEO: begin
                // plane 0 and 3 both read red
                if (r.plane == PLANE_BLUE) begin
                    base = BASE_BLUE;
                end else if (r.plane == PLANE_GREEN) begin
                    base = alt_green ? BASE_GREEN_ALT : BASE_GREEN;
                end else begin
                    base = BASE_RED;
                end
                x.access_valid = 1'b1;
                x.bank         = BANK_VID;
                x.offset       = base + {2'b00, r.address[13:0]} + {8'h00, r.plane_step};
                x.force_zero   = !planes_shown;
            end
            default: ;
        endcase
        return x;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned exp_val,
                                   input int unsigned got_val);
        if (fail_total < PRINT_CAP) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $realtime, what, exp_val, got_val);
        end
        fail_total++;
    endtask

    // Channel monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PAGE_COUNT; p++) begin
                rd_map[p] = (first_addr(p) <= ROM_LAST) ? BANK_ROM : BANK_USER;
                fe_map[p] = rd_map[p];
                wr_map[p] = BANK_USER;
            end
            alt_green    = 1'b0;
            planes_shown = 1'b1;
            disk_present = 1'b1;
            disk_disable = 1'b0;
            expected_xlat.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_DISK_PRESENT) begin
                    disk_present = i_cfg_data;
                end else begin
                    disk_disable = i_cfg_data;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                seen_req.req_type   = i_s_tuser;
                seen_req.address    = i_s_tdata[15:0];
                seen_req.data       = i_s_tdata[23:16];
                seen_req.plane      = i_s_tdata[25:24];
                seen_req.plane_step = i_s_tdata[33:26];
                expected_xlat.push_back(translate_req(seen_req));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.access_valid = i_m_tuser;
                got.bank         = t_bank'(i_m_tdata[1:0]);
                got.offset       = i_m_tdata[17:2];
                got.force_zero   = i_m_tdata[18];
                if (expected_xlat.size() == 0) begin
                    report_mismatch("unrequested result", 32'd0, 32'(got));
                end else begin
                    want = expected_xlat.pop_front();
                    if (got.access_valid !== want.access_valid) begin
                        report_mismatch("access_valid", 32'(want.access_valid),
                                        32'(got.access_valid));
                    end
                    if (got.bank !== want.bank) begin
                        report_mismatch("bank_select", 32'(want.bank), 32'(got.bank));
                    end
                    if (got.offset !== want.offset) begin
                        report_mismatch("bank_offset", 32'(want.offset), 32'(got.offset));
                    end
                    if (got.force_zero !== want.force_zero) begin
                        report_mismatch("force_zero", 32'(want.force_zero),
                                        32'(got.force_zero));
                    end
                end
            end
        end
        o_pending <= expected_xlat.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank map unit testbench
// Drives directed and random requests, bank latch and video port writes
// through the unit under several disk ROM settings, with random idling on
// both streams, one long output hold-off and one no-idle stretch. The
// checker predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import bmmu_pkg::*;

    localparam int RESET_CYCLES   = 9;
    localparam int PHASE_COUNT    = 5;
    localparam int PHASE_ITEMS    = 245;
    localparam int IDLE_PCT       = 21;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 10;

    // Request kinds 5..7 are unused by the unit
    localparam logic [2:0] REQ_SPARE = 3'd5;
    localparam logic [1:0] PLANE_RED     = 2'd0;
    localparam logic [1:0] PLANE_RED_ALT = 2'd3;

    // Disk ROM settings per phase, bit n for phase n
    localparam logic [PHASE_COUNT-1:0] PH_PRESENT = 5'b10101;
    localparam logic [PHASE_COUNT-1:0] PH_DISABLE = 5'b01100;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic        cfg_data  = 1'b0;

    int   pending;
    int   fail_count;
    int   quiet_cycles = 0;
    bit   tx_idle_on   = 1'b1;
    bit   rx_idle_on   = 1'b1;
    logic rx_hold_req  = 1'b0;
    bit   rx_hold_done = 1'b0;

    always #1 clk = ~clk;

    banked_memory_map_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bank_map_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Watchdog: too long without any handshake ends the run
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin : rx_side
        forever begin
            @(posedge clk);
            if (rx_hold_req && !rx_hold_done) begin
                rx_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= !(rx_idle_on && ($urandom_range(99) < IDLE_PCT));
        end
    end

    function automatic t_req mk_req(input logic [2:0] kind, input logic [15:0] addr,
                                    input logic [7:0] val, input logic [1:0] pl,
                                    input logic [7:0] stp);
        t_req r;
        r.req_type   = kind;
        r.address    = addr;
        r.data       = val;
        r.plane      = pl;
        r.plane_step = stp;
        return r;
    endfunction

    // Random request, weighted toward port writes that reshape the maps
    function automatic t_req random_req();
        t_req r;
        int   pick;
        r = mk_req(REQ_READ, 16'($urandom), 8'($urandom), 2'($urandom), 8'($urandom));
        pick = $urandom_range(99);
        if (pick < 12) begin
            r.req_type     = REQ_PORT;
            r.address[7:0] = PORT_BANK;
        end else if (pick < 18) begin
            r.req_type     = REQ_PORT;
            r.address[7:0] = PORT_VIDEO;
        end else if (pick < 21) begin
            r.req_type = REQ_PORT;
        end else if (pick < 40) begin
            r.req_type = REQ_READ;
        end else if (pick < 58) begin
            r.req_type = REQ_FETCH;
        end else if (pick < 74) begin
            r.req_type = REQ_WRITE;
        end else if (pick < 95) begin
            r.req_type = REQ_VIDEO;
        end else begin
            r.req_type = REQ_SPARE + 3'($urandom_range(2));
        end
        return r;
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_req(input t_req r);
        while (tx_idle_on && ($urandom_range(99) < IDLE_PCT)) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, r.plane_step, r.plane, r.data, r.address};
        s_tuser  <= r.req_type;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_disk_cfg(input logic present, input logic disable_ovl);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DISK_PRESENT;
        cfg_data  <= present;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= CFG_DISK_DISABLE;
        cfg_data  <= disable_ovl;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin : stimulus
        t_req dir_q [$];

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: power-on maps, video planes, latch rules, odd requests
        dir_q.push_back(mk_req(REQ_READ,  16'h0000, 8'h00, PLANE_RED, 8'h00));
        dir_q.push_back(mk_req(REQ_FETCH, 16'h5FFF, 8'h00, PLANE_RED, 8'h00));
        dir_q.push_back(mk_req(REQ_WRITE, 16'hFFFF, 8'hFF, PLANE_RED, 8'h00));
        dir_q.push_back(mk_req(REQ_READ,  16'hE000, 8'h00, PLANE_RED, 8'h00));
        dir_q.push_back(mk_req(REQ_VIDEO, 16'hFFFF, 8'h00, PLANE_RED, 8'hFF));
        dir_q.push_back(mk_req(REQ_VIDEO, 16'h0000, 8'h00, PLANE_BLUE, 8'h00));
        // alt green on, planes blanked
        dir_q.push_back(mk_req(REQ_PORT,  16'hFF80, 8'h30, PLANE_RED, 8'h00));
        dir_q.push_back(mk_req(REQ_VIDEO, 16'h3FFF, 8'h00, PLANE_GREEN, 8'h80));
        dir_q.push_back(mk_req(REQ_VIDEO, 16'h1234, 8'h00, PLANE_RED_ALT, 8'h01));
        dir_q.push_back(mk_req(REQ_PORT,  16'h0080, 8'h00, PLANE_RED, 8'h00));
        // all user RAM, ROM and disk ROM overlays
        dir_q.push_back(mk_req(REQ_PORT,  16'h0082, 8'h00, PLANE_RED, 8'h00));
        dir_q.push_back(mk_req(REQ_READ,  16'hFFFF, 8'h00, PLANE_RED, 8'h00));
        // write bank four, read and fetch video, no ROM
        dir_q.push_back(mk_req(REQ_PORT,  16'h0082, 8'hFF, PLANE_RED, 8'h00));
        dir_q.push_back(mk_req(REQ_FETCH, 16'h0000, 8'h00, PLANE_RED, 8'h00));
        dir_q.push_back(mk_req(REQ_WRITE, 16'h8000, 8'h00, PLANE_RED, 8'h00));
        // write video, read video / fetch user, ROM back
        dir_q.push_back(mk_req(REQ_PORT,  16'h0082, 8'hC3, PLANE_RED, 8'h00));
        dir_q.push_back(mk_req(REQ_READ,  16'h6000, 8'h00, PLANE_RED, 8'h00));
        // write map kept, read/fetch bank four
        dir_q.push_back(mk_req(REQ_PORT,  16'h0082, 8'h8D, PLANE_RED, 8'h00));
        dir_q.push_back(mk_req(REQ_READ,  16'h2000, 8'h00, PLANE_RED, 8'h00));
        // select without bit 0: read/fetch maps kept
        dir_q.push_back(mk_req(REQ_PORT,  16'h0082, 8'h8C, PLANE_RED, 8'h00));
        dir_q.push_back(mk_req(REQ_FETCH, 16'hC000, 8'h00, PLANE_RED, 8'h00));
        // some other port is ignored
        dir_q.push_back(mk_req(REQ_PORT,  16'h1281, 8'hFF, PLANE_RED, 8'h00));
        dir_q.push_back(mk_req(REQ_WRITE, 16'h4000, 8'h00, PLANE_RED, 8'h00));
        dir_q.push_back(mk_req(REQ_SPARE, 16'hFFFF, 8'hFF, PLANE_RED_ALT, 8'hFF));
        dir_q.push_back(mk_req(REQ_SPARE + 3'd2, 16'h0000, 8'h00, PLANE_RED, 8'h00));
        foreach (dir_q[k]) begin
            send_req(dir_q[k]);
        end

        // Random phases, one disk ROM setting each
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            settle_idle();
            write_disk_cfg(PH_PRESENT[ph], PH_DISABLE[ph]);
            tx_idle_on = (ph != 3);
            rx_idle_on = (ph != 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long output hold-off while requests keep coming
                if (ph == 1 && n == 60) begin
                    rx_hold_req <= 1'b1;
                end
                send_req(random_req());
            end
        end

        settle_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### banked_memory_map_unit.f
sv/bmmu_pkg.sv
sv/bmmu_bank_map.sv
sv/bmmu_video.sv
sv/banked_memory_map_unit.sv
tb/sv/bank_map_checker.sv
tb/sv/testbench.sv
